// ===== design/vole_pkg.sv =====
package vole_pkg;

  // memory and register file sizes
  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  // program counter and start address after reset
  localparam logic [7:0] START_RESET = 8'd10;

  // item kinds
  localparam logic [2:0] KIND_WRITE_MEM = 3'd0;
  localparam logic [2:0] KIND_READ_MEM  = 3'd1;
  localparam logic [2:0] KIND_READ_REG  = 3'd2;
  localparam logic [2:0] KIND_STEP      = 3'd3;
  localparam logic [2:0] KIND_RESTART   = 3'd4;

  // opcodes
  localparam logic [3:0] OP_BAD_0  = 4'h0;
  localparam logic [3:0] OP_LOAD   = 4'h1;
  localparam logic [3:0] OP_LOADI  = 4'h2;
  localparam logic [3:0] OP_STORE  = 4'h3;
  localparam logic [3:0] OP_MOVE   = 4'h4;
  localparam logic [3:0] OP_ADD    = 4'h5;
  localparam logic [3:0] OP_FADD   = 4'h6;
  localparam logic [3:0] OP_OR     = 4'h7;
  localparam logic [3:0] OP_AND    = 4'h8;
  localparam logic [3:0] OP_XOR    = 4'h9;
  localparam logic [3:0] OP_ROT    = 4'hA;
  localparam logic [3:0] OP_JEQ    = 4'hB;
  localparam logic [3:0] OP_HALT   = 4'hC;
  localparam logic [3:0] OP_JGT    = 4'hD;
  localparam logic [3:0] OP_BAD_E  = 4'hE;
  localparam logic [3:0] OP_BAD_F  = 4'hF;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] address;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  program_counter;
    logic        halted;
    logic        fault;
    logic [15:0] instruction_word;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch_lo;
    logic decode;
    logic exec;
    logic capture;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic halted;
  } dp_status_t;

  // true when a byte address maps to an existing memory cell
  function automatic logic mem_in_range(input logic [7:0] a);
    return {1'b0, a} < 9'(MEM_DEPTH);
  endfunction

endpackage

// ===== design/vole_ram.sv =====
module vole_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vole_ctrl.sv =====
module vole_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  vole_pkg::dp_status_t status,
  output vole_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_HI,
    S_FETCH_LO,
    S_EXEC,
    S_READ,
    S_OUTPUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.fetch_lo = (state == S_FETCH_HI);
    cmd.decode   = (state == S_FETCH_LO);
    cmd.exec     = (state == S_EXEC);
    cmd.capture  = (state == S_READ);
    cmd.load_out = (state == S_OUTPUT) && out_free;
  end

  // sequencer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == vole_pkg::KIND_STEP && !status.halted) begin
              state <= S_FETCH_HI;
            end else if (in_kind inside {vole_pkg::KIND_READ_MEM,
                                         vole_pkg::KIND_READ_REG}) begin
              state <= S_READ;
            end else begin
              state <= S_OUTPUT;
            end
          end
        end
        S_FETCH_HI: state <= S_FETCH_LO;
        S_FETCH_LO: state <= S_EXEC;
        S_EXEC:     state <= S_OUTPUT;
        S_READ:     state <= S_OUTPUT;
        S_OUTPUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready)
    else $error("item accepted while another is in flight");

  // a result appears only from the output state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUTPUT)
    else $error("result valid raised outside the output state");

  // nothing moves during the memory clear
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !in_ready && !out_valid)
    else $error("handshake active during memory clear");
`endif

endmodule

// ===== design/vole_datapath.sv =====
module vole_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  vole_pkg::dp_cmd_t    cmd,
  output vole_pkg::dp_status_t status,
  input  vole_pkg::in_item_t   in_item,
  output vole_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  // architectural state
  logic [7:0]  start_address;
  logic [7:0]  pc;
  logic        halted;
  logic        fault;
  logic [15:0] ir;
  logic [7:0]  ir_hi;
  logic [2:0]  kind;
  logic [7:0]  read_data;
  logic [vole_pkg::MEM_AW-1:0] clr_addr;
  logic [vole_pkg::REG_COUNT-1:0] rf_valid;

  // memory port signals
  logic                        mem_we;
  logic [7:0]                  mem_waddr;
  logic [7:0]                  mem_wdata;
  logic [7:0]                  mem_raddr;
  logic [7:0]                  mem_rdata;
  logic                        mem_rd_ok;
  logic [7:0]                  mem_q;
  logic [vole_pkg::MEM_AW-1:0] ram_waddr;

  // register file port signals
  logic                        rf_we;
  logic [vole_pkg::REG_AW-1:0] rf_waddr;
  logic [7:0]                  rf_wdata;
  logic [vole_pkg::REG_AW-1:0] rf_raddr_a;
  logic [vole_pkg::REG_AW-1:0] rf_raddr_b;
  logic [7:0]                  rf_rdata_a;
  logic [7:0]                  rf_rdata_b;
  logic                        rf_ok_a;
  logic                        rf_ok_b;
  logic [7:0]                  ra;
  logic [7:0]                  rb;

  // decode of the executing instruction
  logic [3:0] op;
  logic [3:0] r_idx;
  logic [3:0] s_idx;
  logic [3:0] t_idx;
  logic [7:0] xy;
  logic [3:0] dec_op;
  logic [7:0] pc_next;
  logic [7:0] alu_out;
  logic [2:0] rot_k;

  assign op    = ir[15:12];
  assign r_idx = ir[11:8];
  assign s_idx = ir[7:4];
  assign t_idx = ir[3:0];
  assign xy    = ir[7:0];
  assign rot_k = t_idx[2:0];

  assign mem_q  = mem_rd_ok ? mem_rdata : 8'd0;
  assign ra     = rf_ok_a ? rf_rdata_a : 8'd0;
  assign rb     = rf_ok_b ? rf_rdata_b : 8'd0;
  assign dec_op = ir_hi[7:4];

  assign status.clear_done = (clr_addr == vole_pkg::MEM_AW'(vole_pkg::MEM_DEPTH - 1));
  assign status.halted     = halted;

  // exponent and mantissa add
  function automatic logic [7:0] float_add(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] ea;
    logic [3:0] eb;
    logic [3:0] ma;
    logic [3:0] mb;
    logic [3:0] e;
    logic [4:0] m;
    ea = a[7:4];
    eb = b[7:4];
    ma = a[3:0];
    mb = b[3:0];
    if (ea > eb) begin
      mb = mb >> (ea - eb);
      e  = ea;
    end else begin
      ma = ma >> (eb - ea);
      e  = eb;
    end
    m = {1'b0, ma} + {1'b0, mb};
    if (m[4]) begin
      m = m >> 1;
      e = e + 4'd1;
    end
    return {e, m[3:0]};
  endfunction

  // program memory write port: clear pass, item write, store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = 8'd0;
    mem_wdata = 8'd0;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = 8'(clr_addr);
    end else if (cmd.accept && in_item.kind == vole_pkg::KIND_WRITE_MEM) begin
      mem_we    = vole_pkg::mem_in_range(in_item.address);
      mem_waddr = in_item.address;
      mem_wdata = in_item.write_data;
    end else if (cmd.exec && op == vole_pkg::OP_STORE) begin
      mem_we    = vole_pkg::mem_in_range(xy);
      mem_waddr = xy;
      mem_wdata = ra;
    end
  end

  assign ram_waddr = mem_waddr[vole_pkg::MEM_AW-1:0];

  // program memory read address
  always_comb begin
    mem_raddr = pc;
    if (cmd.accept) begin
      mem_raddr = (in_item.kind == vole_pkg::KIND_STEP) ? pc : in_item.address;
    end else if (cmd.fetch_lo) begin
      mem_raddr = pc + 8'd1;
    end else if (cmd.decode) begin
      mem_raddr = mem_q;
    end
  end

  vole_ram #(
    .WIDTH (8),
    .DEPTH (vole_pkg::MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ram_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr[vole_pkg::MEM_AW-1:0]),
    .rdata (mem_rdata)
  );

  // register file read addresses: the item address on accept, else operands picked from the fetched bytes
  always_comb begin
    rf_raddr_a = '0;
    rf_raddr_b = '0;
    if (cmd.accept) begin
      rf_raddr_a = in_item.address[vole_pkg::REG_AW-1:0];
    end else if (cmd.decode) begin
      if (dec_op inside {vole_pkg::OP_MOVE, vole_pkg::OP_ADD, vole_pkg::OP_FADD,
                         vole_pkg::OP_OR, vole_pkg::OP_AND, vole_pkg::OP_XOR}) begin
        rf_raddr_a = mem_q[7:4];
      end else begin
        rf_raddr_a = ir_hi[3:0];
      end
      if (dec_op inside {vole_pkg::OP_ADD, vole_pkg::OP_FADD,
                         vole_pkg::OP_OR, vole_pkg::OP_AND, vole_pkg::OP_XOR}) begin
        rf_raddr_b = mem_q[3:0];
      end
    end
  end

  // execute: register write-back, next program counter
  always_comb begin
    alu_out  = 8'd0;
    rf_we    = 1'b0;
    rf_waddr = r_idx;
    pc_next  = pc + 8'd2;
    case (op)
      vole_pkg::OP_LOAD:  begin rf_we = 1'b1; alu_out = mem_q; end
      vole_pkg::OP_LOADI: begin rf_we = 1'b1; alu_out = xy; end
      vole_pkg::OP_STORE: ;
      vole_pkg::OP_MOVE:  begin rf_we = 1'b1; rf_waddr = t_idx; alu_out = ra; end
      vole_pkg::OP_ADD:   begin rf_we = 1'b1; alu_out = ra + rb; end
      vole_pkg::OP_FADD:  begin rf_we = 1'b1; alu_out = float_add(ra, rb); end
      vole_pkg::OP_OR:    begin rf_we = 1'b1; alu_out = ra | rb; end
      vole_pkg::OP_AND:   begin rf_we = 1'b1; alu_out = ra & rb; end
      vole_pkg::OP_XOR:   begin rf_we = 1'b1; alu_out = ra ^ rb; end
      vole_pkg::OP_ROT: begin
        rf_we   = 1'b1;
        alu_out = 8'(({ra, ra} >> rot_k));
      end
      vole_pkg::OP_JEQ: begin
        if (ra == rb) begin
          pc_next = xy;
        end
      end
      vole_pkg::OP_HALT: pc_next = pc;
      vole_pkg::OP_JGT: begin
        if ($signed(ra) > $signed(rb)) begin
          pc_next = xy;
        end
      end
      default: ;
    endcase
    rf_we    = rf_we && cmd.exec;
    rf_wdata = alu_out;
  end

  // two copies of the register file give two read ports
  vole_ram #(
    .WIDTH (8),
    .DEPTH (vole_pkg::REG_COUNT)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_a),
    .rdata (rf_rdata_a)
  );

  vole_ram #(
    .WIDTH (8),
    .DEPTH (vole_pkg::REG_COUNT)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_b),
    .rdata (rf_rdata_b)
  );

  // read-side tags that travel with the registered read data
  always_ff @(posedge clk) begin
    mem_rd_ok <= vole_pkg::mem_in_range(mem_raddr);
    rf_ok_a   <= rf_valid[rf_raddr_a];
    rf_ok_b   <= rf_valid[rf_raddr_b];
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= vole_pkg::START_RESET;
      pc            <= vole_pkg::START_RESET;
      halted        <= 1'b0;
      fault         <= 1'b0;
      ir            <= 16'd0;
      clr_addr      <= '0;
      rf_valid      <= '0;
    end else begin
      if (cfg_we) begin
        start_address <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      if (cmd.accept && in_item.kind == vole_pkg::KIND_RESTART) begin
        pc     <= start_address;
        halted <= 1'b0;
        fault  <= 1'b0;
      end
      if (cmd.decode) begin
        ir <= {ir_hi, mem_q};
      end
      if (cmd.exec) begin
        pc <= pc_next;
        if (op == vole_pkg::OP_HALT) begin
          halted <= 1'b1;
        end else if (op inside {vole_pkg::OP_BAD_0, vole_pkg::OP_BAD_E,
                                vole_pkg::OP_BAD_F}) begin
          halted <= 1'b1;
          fault  <= 1'b1;
        end
      end
    end
  end

  // item payload, fetched high byte and read result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind      <= in_item.kind;
      read_data <= 8'd0;
    end
    if (cmd.fetch_lo) begin
      ir_hi <= mem_q;
    end
    if (cmd.capture) begin
      read_data <= (kind == vole_pkg::KIND_READ_MEM) ? mem_q : ra;
    end
    if (cmd.load_out) begin
      out_item.read_data        <= read_data;
      out_item.program_counter  <= pc;
      out_item.halted           <= halted;
      out_item.fault            <= fault;
      out_item.instruction_word <= ir;
    end
  end

`ifndef ASSERT_OFF
  // a fault always stops execution
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    fault |-> halted)
    else $error("fault set without halt");

  // the program counter moves only on restart or execute
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.exec && !cmd.accept) |=> $stable(pc))
    else $error("program counter changed without a command");

  // a halted cpu never executes
  a_no_exec_halted: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !halted)
    else $error("instruction executed while halted");
`endif

endmodule

// ===== design/vole_cpu_instruction_step_core.sv =====
// Eight-bit teaching CPU with sixteen registers and a byte memory. Each input item
// writes or reads a memory byte, reads a register, restarts at start_address, or
// executes one two-byte instruction, and yields one result item with the read byte,
// the program counter, the halt and fault flags and the last fetched instruction.
// A step item on a running CPU runs from acceptance to the next acceptance in order:
// the single read port of the program memory returns the high byte, then the low byte,
// then the data byte while the instruction executes, then a result state and an idle
// state. Read items pass through a read state; writes, restarts, unused kinds and steps
// while halted go straight to the result state, which waits while the output stalls.
// After reset the block zeroes the program memory, one byte a cycle for all MEM_DEPTH (256)
// bytes, before it takes its first item; start_address may be written at any idle time.
module vole_cpu_instruction_step_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vole_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output vole_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  vole_pkg::dp_cmd_t    cmd;
  vole_pkg::dp_status_t status;

  vole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_item.kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  vole_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
